[hdl/euclidean_distance_top_assert.svh]
// ---------------------------------------------------------------------------
// Assertion macros shared by the distance block.
// ---------------------------------------------------------------------------
`ifndef EUCLIDEAN_DISTANCE_TOP_ASSERT_SVH
`define EUCLIDEAN_DISTANCE_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent
`define EUCL_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define EUCL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/eucl_pkg.sv]
// ---------------------------------------------------------------------------
// eucl_pkg
// Widths, limits and shared types of the distance block.
// ---------------------------------------------------------------------------
package eucl_pkg;

  // Field widths of the channels
  localparam int unsigned FIELD_W = 16;
  localparam int unsigned DIST_W  = 27;
  localparam int unsigned ACC_BITS = 38;

  // Saturation limit of the accumulator
  localparam logic [ACC_BITS-1:0] ACC_MAX = {ACC_BITS{1'b1}};

  // Parameter defaults
  localparam int unsigned ELEM_WIDTH_DEF = 16;
  localparam int unsigned FRAC_BITS_DEF  = 8;

  // Finished sum travelling alongside the root cells
  typedef struct packed {
    logic [ACC_BITS-1:0] sum;
    logic                sat;
  } eucl_meta_t;

endpackage

[hdl/eucl_in_if.sv]
// ---------------------------------------------------------------------------
// eucl_in_if
// Input channel: one coordinate pair and a last flag per beat.
// ---------------------------------------------------------------------------
interface eucl_in_if
  import eucl_pkg::*;
  ;
  logic                      valid;
  logic                      ready;
  logic signed [FIELD_W-1:0] elem_a;
  logic signed [FIELD_W-1:0] elem_b;
  logic                      last;

  modport source (output valid, output elem_a, output elem_b, output last, input ready);
  modport sink   (input valid, input elem_a, input elem_b, input last, output ready);
endinterface

[hdl/eucl_out_if.sv]
// ---------------------------------------------------------------------------
// eucl_out_if
// Result channel: squared sum, distance and saturation flag per beat.
// ---------------------------------------------------------------------------
interface eucl_out_if
  import eucl_pkg::*;
  ;
  logic                valid;
  logic                ready;
  logic [DIST_W-1:0]   distance;
  logic [ACC_BITS-1:0] squared_sum;
  logic                saturated;

  modport source (output valid, output distance, output squared_sum, output saturated,
                  input ready);
  modport sink   (input valid, input distance, input squared_sum, input saturated,
                  output ready);
endinterface

[hdl/eucl_acc.sv]
// ---------------------------------------------------------------------------
// eucl_acc
// Squares coordinate differences and accumulates them with saturation.
// ---------------------------------------------------------------------------
module eucl_acc
  import eucl_pkg::*;
#(
  parameter int unsigned ELEM_WIDTH = ELEM_WIDTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      adv,
  input  logic                      take,
  input  logic signed [FIELD_W-1:0] elem_a,
  input  logic signed [FIELD_W-1:0] elem_b,
  input  logic                      last,
  output logic                      seed_valid,
  output eucl_meta_t                seed
);

  `include "euclidean_distance_top_assert.svh"

  localparam int unsigned SQ_W = 2 * ELEM_WIDTH;

  logic signed [ELEM_WIDTH:0]   a_x;
  logic signed [ELEM_WIDTH:0]   b_x;
  logic signed [ELEM_WIDTH:0]   d;
  logic        [ELEM_WIDTH:0]   ad_full;
  logic        [ELEM_WIDTH-1:0] ad;
  logic        [SQ_W-1:0]       sq_prod;

  logic                sq_valid;
  logic                sq_last;
  logic [SQ_W-1:0]     sq;

  logic [ACC_BITS-1:0] acc;
  logic                flag;
  logic [ACC_BITS:0]   total;
  logic [ACC_BITS-1:0] acc_next;
  logic                flag_next;

  // Sign-extend the low bits and take the magnitude of the difference
  assign a_x     = {elem_a[ELEM_WIDTH-1], elem_a[ELEM_WIDTH-1:0]};
  assign b_x     = {elem_b[ELEM_WIDTH-1], elem_b[ELEM_WIDTH-1:0]};
  assign d       = a_x - b_x;
  assign ad_full = d[ELEM_WIDTH] ? $unsigned(-d) : $unsigned(d);
  assign ad      = ad_full[ELEM_WIDTH-1:0];
  assign sq_prod = SQ_W'(ad * ad);

  // Register the square
  always_ff @(posedge clk) begin
    if (rst) begin
      sq_valid <= 1'b0;
    end else if (adv) begin
      sq_valid <= take;
    end
    if (adv) begin
      sq      <= sq_prod;
      sq_last <= last;
    end
  end

  // Saturating add
  always_comb begin
    total     = {1'b0, acc} + {{(ACC_BITS + 1 - SQ_W){1'b0}}, sq};
    acc_next  = total[ACC_BITS] ? ACC_MAX : total[ACC_BITS-1:0];
    flag_next = flag | total[ACC_BITS];
  end

  // Accumulate; on the last beat hand the sum on and clear
  always_ff @(posedge clk) begin
    if (rst) begin
      acc        <= '0;
      flag       <= 1'b0;
      seed_valid <= 1'b0;
    end else if (adv) begin
      seed_valid <= sq_valid & sq_last;
      if (sq_valid) begin
        if (sq_last) begin
          acc  <= '0;
          flag <= 1'b0;
        end else begin
          acc  <= acc_next;
          flag <= flag_next;
        end
      end
    end
    if (adv) begin
      seed.sum <= acc_next;
      seed.sat <= flag_next;
    end
  end

  `EUCL_ASSERT_NEXT(a_acc_hold, clk, rst, !rst && !adv, $stable(acc) && $stable(flag),
    "accumulator moved while stalled")
  `EUCL_ASSERT_NOW(a_flag_max, clk, rst, flag, acc == ACC_MAX,
    "saturation flag set without a full accumulator")
  `EUCL_ASSERT_NEXT(a_seed_sat, clk, rst, !rst && adv && sq_valid && sq_last && flag,
    seed_valid && seed.sat, "saturation lost at end of vector")

endmodule

[hdl/eucl_root_cell.sv]
// ---------------------------------------------------------------------------
// eucl_root_cell
// One digit step of the square root: takes two radicand bits, adds one
// root bit and passes everything on to the next cell.
// ---------------------------------------------------------------------------
module eucl_root_cell
  import eucl_pkg::*;
#(
  parameter int unsigned ROOT_W = 27,
  parameter int unsigned RAD_W  = 54
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              adv,
  input  logic              up_valid,
  input  logic [RAD_W-1:0]  up_rad,
  input  logic [ROOT_W-1:0] up_root,
  input  logic [ROOT_W+1:0] up_rem,
  input  eucl_meta_t        up_meta,
  output logic              dn_valid,
  output logic [RAD_W-1:0]  dn_rad,
  output logic [ROOT_W-1:0] dn_root,
  output logic [ROOT_W+1:0] dn_rem,
  output eucl_meta_t        dn_meta
);

  localparam int unsigned REM_W = ROOT_W + 2;

  logic [REM_W+1:0] ext;
  logic [REM_W+1:0] trial;
  logic [REM_W+1:0] diff;
  logic             fits;

  // Trial subtraction of (root << 2) | 1
  always_comb begin
    ext   = {up_rem, up_rad[RAD_W-1 -: 2]};
    trial = {{(REM_W - ROOT_W){1'b0}}, up_root, 2'b01};
    diff  = ext - trial;
    fits  = (ext >= trial);
  end

  // Advance one step down the chain
  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (adv) begin
      dn_valid <= up_valid;
    end
    if (adv) begin
      dn_rad  <= {up_rad[RAD_W-3:0], 2'b00};
      dn_root <= {up_root[ROOT_W-2:0], fits};
      dn_rem  <= fits ? diff[REM_W-1:0] : ext[REM_W-1:0];
      dn_meta <= up_meta;
    end
  end

endmodule

[hdl/euclidean_distance_top.sv]
// ---------------------------------------------------------------------------
// euclidean_distance_top
// Streaming Euclidean distance between two vectors.
// ---------------------------------------------------------------------------
// Usage: the item channel takes one coordinate pair (elem_a, elem_b) per
// beat; last marks the final pair of a vector. Only the last beat of a
// vector produces a beat on the result channel, carrying the squared sum
// (saturated at 2^38 - 1), its square root in fixed point with FRAC_BITS
// fractional bits, and the saturation flag.
// Throughput: one coordinate pair per cycle while the chain is not stalled,
// set by the squaring stage and the accumulator loop.
// Pipeline: after its last beat is accepted, a result passes one squaring
// stage, one accumulate stage, then one root cell per radicand bit pair.
// Stall: the whole chain holds while a result waits and the receiver is
// not ready; item.ready then drops in the same cycle.
// Reset: clears the accumulator, the saturation flag and all stage valids;
// the block takes items in the first cycle after reset.
// ---------------------------------------------------------------------------
module euclidean_distance_top
  import eucl_pkg::*;
#(
  parameter int unsigned ELEM_WIDTH = ELEM_WIDTH_DEF,
  parameter int unsigned FRAC_BITS  = FRAC_BITS_DEF
) (
  input logic      clk,
  input logic      rst,
  eucl_in_if.sink  item,
  eucl_out_if.source result
);

  `include "euclidean_distance_top_assert.svh"

  localparam int unsigned PAIRS  = ACC_BITS / 2 + FRAC_BITS;
  localparam int unsigned ROOT_W = PAIRS;
  localparam int unsigned RAD_W  = 2 * PAIRS;
  localparam int unsigned REM_W  = ROOT_W + 2;

  logic       adv;
  logic       seed_valid;
  eucl_meta_t seed;

  logic              valid [0:PAIRS];
  logic [RAD_W-1:0]  rad   [0:PAIRS];
  logic [ROOT_W-1:0] root  [0:PAIRS];
  logic [REM_W-1:0]  rem   [0:PAIRS];
  eucl_meta_t        meta  [0:PAIRS];

  logic [ROOT_W+DIST_W-1:0] root_ext;

  // Move the chain whenever the result register is free or being taken
  assign adv        = !result.valid || result.ready;
  assign item.ready = adv;

  eucl_acc #(
    .ELEM_WIDTH (ELEM_WIDTH)
  ) u_acc (
    .clk        (clk),
    .rst        (rst),
    .adv        (adv),
    .take       (item.valid),
    .elem_a     (item.elem_a),
    .elem_b     (item.elem_b),
    .last       (item.last),
    .seed_valid (seed_valid),
    .seed       (seed)
  );

  // Seed the first cell: radicand is the sum scaled by 2^(2*FRAC_BITS)
  assign valid[0] = seed_valid;
  assign rad[0]   = RAD_W'({seed.sum, {(2 * FRAC_BITS){1'b0}}});
  assign root[0]  = '0;
  assign rem[0]   = '0;
  assign meta[0]  = seed;

  for (genvar i = 0; i < PAIRS; i++) begin : g_cell
    eucl_root_cell #(
      .ROOT_W (ROOT_W),
      .RAD_W  (RAD_W)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .adv      (adv),
      .up_valid (valid[i]),
      .up_rad   (rad[i]),
      .up_root  (root[i]),
      .up_rem   (rem[i]),
      .up_meta  (meta[i]),
      .dn_valid (valid[i+1]),
      .dn_rad   (rad[i+1]),
      .dn_root  (root[i+1]),
      .dn_rem   (rem[i+1]),
      .dn_meta  (meta[i+1])
    );
  end

  // Drive the result from the last cell
  assign root_ext           = {{DIST_W{1'b0}}, root[PAIRS]};
  assign result.valid       = valid[PAIRS];
  assign result.distance    = root_ext[DIST_W-1:0];
  assign result.squared_sum = meta[PAIRS].sum;
  assign result.saturated   = meta[PAIRS].sat;

  `EUCL_ASSERT_NOW(a_sat_full, clk, rst, result.valid && result.saturated,
    result.squared_sum == ACC_MAX, "saturated result without a full sum")
  `EUCL_ASSERT_NOW(a_zero_root, clk, rst, result.valid && (result.squared_sum == '0),
    result.distance == '0, "non-zero distance for a zero sum")
  `EUCL_ASSERT_NEXT(a_res_hold, clk, rst, result.valid && !result.ready,
    result.valid && $stable(result.squared_sum) && $stable(result.distance),
    "result beat changed while stalled")

endmodule

[verif/euclidean_distance_top_tb.sv]
// ---------------------------------------------------------------------------
// euclidean_distance_top_tb
// Self-checking bench for the streaming Euclidean distance block. Vector
// pairs are queued up front and sent in bursts. A bit-accurate model
// accumulates squared differences with saturation and takes a digit-wise
// fixed-point root. Each result beat is compared in order against that
// model, while the result side stalls on a pattern of its own.
// ---------------------------------------------------------------------------
module euclidean_distance_top_tb
  import eucl_pkg::*;
  ;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ELEM_W     = ELEM_WIDTH_DEF;
  localparam int unsigned FRAC       = FRAC_BITS_DEF;
  localparam int unsigned ROOT_PAIRS = (ACC_BITS + 2 * FRAC) / 2;
  localparam int unsigned DRAIN_CYC  = 2 + 19 + FRAC + 20;
  localparam int unsigned QUIET_MAX  = 2000;
  localparam int unsigned ITEM_GOAL  = 1100;

  typedef struct {
    logic [FIELD_W-1:0] a;
    logic [FIELD_W-1:0] b;
    logic               last;
  } coord_pair_t;

  typedef struct {
    logic [DIST_W-1:0]   distance;
    logic [ACC_BITS-1:0] squared_sum;
    logic                saturated;
  } dist_result_t;

  typedef enum logic [1:0] {
    SINK_OPEN,
    SINK_COIN,
    SINK_SPARSE,
    SINK_HOLD
  } sink_mode_t;

  typedef enum logic [1:0] {
    COORD_ANY,
    COORD_EDGE,
    COORD_NEAR,
    COORD_WIDE
  } coord_kind_t;

  logic clk;
  logic rst;

  eucl_in_if  item_ch ();
  eucl_out_if result_ch ();

  euclidean_distance_top dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch)
  );

  coord_pair_t  pair_q[$];
  dist_result_t dist_expect_q[$];

  // Model state of the running sum
  logic [ACC_BITS-1:0] model_sum;
  logic                model_sat;

  int unsigned beats_sent;
  int unsigned beats_total;
  int unsigned mismatches;
  int unsigned quiet_cycles;
  logic        timed_out;

  // Driver pacing and receiver pattern
  int unsigned burst_left;
  int unsigned gap_left;
  sink_mode_t  sink_mode;
  int unsigned sink_left;

  // floor(sqrt(s * 2^(2*FRAC))), two radicand bits per step
  function automatic logic [DIST_W-1:0] fixed_root(input logic [ACC_BITS-1:0] s);
    logic [63:0] radicand;
    logic [63:0] root;
    logic [63:0] rem;
    logic [63:0] trial;
    radicand = 64'(s) << (2 * FRAC);
    root = '0;
    rem  = '0;
    for (int p = ROOT_PAIRS - 1; p >= 0; p--) begin
      rem   = (rem << 2) | ((radicand >> (2 * p)) & 64'd3);
      trial = (root << 2) | 64'd1;
      if (rem >= trial) begin
        rem  = rem - trial;
        root = (root << 1) | 64'd1;
      end else begin
        root = root << 1;
      end
    end
    return root[DIST_W-1:0];
  endfunction

  // Fold one accepted pair into the model; queue a result on the last beat
  function automatic void fold_pair(input logic [FIELD_W-1:0] a, input logic [FIELD_W-1:0] b,
                                    input logic last);
    logic signed [ELEM_W-1:0] a_s;
    logic signed [ELEM_W-1:0] b_s;
    longint                   diff;
    logic [63:0]              sq;
    dist_result_t             res;
    a_s  = a[ELEM_W-1:0];
    b_s  = b[ELEM_W-1:0];
    diff = longint'(a_s) - longint'(b_s);
    if (diff < 0) diff = -diff;
    sq = 64'(diff) * 64'(diff);
    if (sq > 64'(ACC_MAX) - 64'(model_sum)) begin
      model_sum = ACC_MAX;
      model_sat = 1'b1;
    end else begin
      model_sum = model_sum + sq[ACC_BITS-1:0];
    end
    if (last) begin
      res.distance    = fixed_root(model_sum);
      res.squared_sum = model_sum;
      res.saturated   = model_sat;
      dist_expect_q   = {dist_expect_q, res};
      model_sum = '0;
      model_sat = 1'b0;
    end
  endfunction

  function automatic logic [FIELD_W-1:0] pick_coord(input coord_kind_t kind);
    logic [FIELD_W-1:0] v;
    case (kind)
      COORD_EDGE: begin
        case ($urandom_range(3))
          0: v = 16'h8000;
          1: v = 16'h7fff;
          2: v = 16'h0000;
          default: v = 16'hffff;
        endcase
      end
      COORD_NEAR: v = FIELD_W'($urandom_range(64) - 32);
      COORD_WIDE: v = $urandom_range(1) ? 16'h7fff : 16'h8000;
      default: v = FIELD_W'($urandom);
    endcase
    return v;
  endfunction

  // Queue one vector pair of the given length
  task automatic queue_vector(input int unsigned len, input bit full_swing);
    coord_pair_t p;
    coord_kind_t kind;
    for (int unsigned i = 0; i < len; i++) begin
      if (full_swing) begin
        p.a = pick_coord(COORD_WIDE);
        p.b = ~p.a;
      end else begin
        kind = coord_kind_t'($urandom_range(3));
        p.a  = pick_coord(kind);
        p.b  = pick_coord(kind);
      end
      p.last = (i == len - 1);
      pair_q = {pair_q, p};
    end
  endtask

  task automatic queue_pair(input logic [FIELD_W-1:0] a, input logic [FIELD_W-1:0] b,
                            input logic last);
    coord_pair_t p;
    p.a    = a;
    p.b    = b;
    p.last = last;
    pair_q = {pair_q, p};
  endtask

  // Clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Driver: send queued pairs in bursts, fold each accepted beat
  always @(posedge clk) begin
    if (rst) begin
      item_ch.valid <= 1'b0;
      burst_left    <= $urandom_range(1, 40);
      gap_left      <= 0;
    end else begin
      if (item_ch.valid && item_ch.ready) begin
        fold_pair(item_ch.elem_a, item_ch.elem_b, item_ch.last);
        beats_sent <= beats_sent + 1;
      end
      if (!item_ch.valid || item_ch.ready) begin
        if (gap_left != 0) begin
          item_ch.valid <= 1'b0;
          gap_left      <= gap_left - 1;
        end else if (pair_q.size() != 0) begin
          item_ch.valid  <= 1'b1;
          item_ch.elem_a <= pair_q[0].a;
          item_ch.elem_b <= pair_q[0].b;
          item_ch.last   <= pair_q[0].last;
          void'(pair_q.pop_front());
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 40);
            case ($urandom_range(3))
              0: gap_left <= 0;
              1: gap_left <= $urandom_range(1, 3);
              2: gap_left <= $urandom_range(1, 8);
              default: gap_left <= $urandom_range(10, 20);
            endcase
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          item_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: stall according to a mode that changes every stretch
  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
      sink_mode       <= SINK_OPEN;
      sink_left       <= 0;
    end else begin
      if (sink_left == 0) begin
        sink_mode <= sink_mode_t'($urandom_range(3));
        sink_left <= $urandom_range(5, 120);
      end else begin
        sink_left <= sink_left - 1;
      end
      case (sink_mode)
        SINK_OPEN:   result_ch.ready <= 1'b1;
        SINK_COIN:   result_ch.ready <= $urandom_range(1);
        SINK_SPARSE: result_ch.ready <= ($urandom_range(3) == 0);
        default:     result_ch.ready <= (sink_left > 30) ? 1'b1 : 1'b0;
      endcase
    end
  end

  // Monitor: compare each result beat with the oldest expectation
  always @(posedge clk) begin
    dist_result_t exp_r;
    logic         bad;
    bad = 1'b0;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (dist_expect_q.size() == 0) begin
        $display("%0t unexpected result beat: distance %0d squared_sum %0d saturated %0d",
                 $realtime, result_ch.distance, result_ch.squared_sum, result_ch.saturated);
        bad = 1'b1;
      end else begin
        exp_r = dist_expect_q.pop_front();
        if (result_ch.distance !== exp_r.distance) begin
          $display("%0t distance mismatch: expected %0d actual %0d",
                   $realtime, exp_r.distance, result_ch.distance);
          bad = 1'b1;
        end
        if (result_ch.squared_sum !== exp_r.squared_sum) begin
          $display("%0t squared_sum mismatch: expected %0d actual %0d",
                   $realtime, exp_r.squared_sum, result_ch.squared_sum);
          bad = 1'b1;
        end
        if (result_ch.saturated !== exp_r.saturated) begin
          $display("%0t saturated mismatch: expected %0d actual %0d",
                   $realtime, exp_r.saturated, result_ch.saturated);
          bad = 1'b1;
        end
      end
    end
    if (bad) mismatches <= mismatches + 1;
  end

  // Watchdog: count cycles with no beat on either channel
  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_MAX) timed_out <= 1'b1;
    end
  end

  // Stimulus, reset and end of run
  initial begin
    int unsigned len;
    rst             = 1'b1;
    item_ch.valid   = 1'b0;
    item_ch.elem_a  = '0;
    item_ch.elem_b  = '0;
    item_ch.last    = 1'b0;
    result_ch.ready = 1'b0;
    model_sum       = '0;
    model_sat       = 1'b0;
    beats_sent      = 0;
    mismatches      = 0;
    timed_out       = 1'b0;

    // Single-element vectors at the extremes
    queue_pair(16'h0000, 16'h0000, 1'b1);
    queue_pair(16'h7fff, 16'h8000, 1'b1);
    queue_pair(16'h8000, 16'h7fff, 1'b1);
    queue_pair(16'hffff, 16'h0001, 1'b1);
    queue_pair(16'h0001, 16'h0000, 1'b1);
    // Equal extremes cancel out
    queue_pair(16'h8000, 16'h8000, 1'b0);
    queue_pair(16'h7fff, 16'h7fff, 1'b1);
    // Short mixed vectors
    queue_pair(16'h0003, 16'h0000, 1'b0);
    queue_pair(16'h0000, 16'h0004, 1'b1);
    queue_pair(16'h8000, 16'h0000, 1'b0);
    queue_pair(16'h0000, 16'h7fff, 1'b0);
    queue_pair(16'h5555, 16'haaaa, 1'b1);
    queue_pair(16'hffff, 16'hfffe, 1'b0);
    queue_pair(16'h1234, 16'hedcb, 1'b0);
    queue_pair(16'h00ff, 16'hff00, 1'b0);
    queue_pair(16'h7fff, 16'h8000, 1'b1);
    queue_pair(16'h0002, 16'h0002, 1'b1);

    // Random vectors, now and then a full-swing one near or past the limit
    while (pair_q.size() < ITEM_GOAL) begin
      case ($urandom_range(99)) inside
        [0:69]:  queue_vector($urandom_range(1, 8), 1'b0);
        [70:84]: queue_vector($urandom_range(9, 32), 1'b0);
        [85:92]: queue_vector($urandom_range(33, 64), 1'b0);
        [93:95]: queue_vector(64, 1'b1);
        default: begin
          len = $urandom_range(65, 72);
          queue_vector(len - 2, 1'b1);
          queue_vector(2, 1'b0);
          pair_q[pair_q.size() - 3].last = 1'b0;
        end
      endcase
    end
    beats_total = pair_q.size();

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Hold until every beat is sent and every result has come back
    @(negedge clk);
    while (!timed_out && !(beats_sent == beats_total && dist_expect_q.size() == 0))
      @(negedge clk);

    if (timed_out) begin
      $display("== FAIL ==");
    end else begin
      repeat (DRAIN_CYC) @(negedge clk);
      if (mismatches == 0 && dist_expect_q.size() == 0 && !timed_out)
        $display("== PASS ==");
      else
        $display("== FAIL ==");
    end
    $finish;
  end

endmodule
